// ===== design/bounded_deque_with_search_macros.svh =====
// Assertion helpers for the deque top-level design file.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BDWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BDWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bdws_pkg.sv =====
`timescale 1ns / 1ps

package bdws_pkg;

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_REM_FRONT = 3'd2,
        MODE_REM_BACK  = 3'd3,
        MODE_SEARCH    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
    } res_t;

endpackage

// ===== design/bounded_deque_with_search.sv =====
// Results: insert and remove results are registered into the result queue in the cycle after the request;
//   a search reads the stored keys from the front and ends at the first hit or after the last entry.
// Throughput: one insert or remove per cycle while the result queue has room; a search stalls the input
//   until its scan ends, since the key store has a single read port and there is one key comparator.
// Reset (rst_n, asynchronous): empties the deque and the output queue; store contents are kept.
`timescale 1ns / 1ps

`include "bounded_deque_with_search_macros.svh"

module bounded_deque_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bdws_pkg::MODE_W-1:0]       mode,
    input  logic signed [bdws_pkg::KEY_W-1:0] key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bdws_pkg::STATUS_W-1:0]     status,
    output logic [bdws_pkg::POS_W-1:0]        position
);
    import bdws_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic            we;
    logic [AW-1:0]   waddr;
    logic [KEY_W-1:0] wdata;
    logic [AW-1:0]   raddr;
    logic [KEY_W-1:0] rdata;
    logic            res_done;
    res_t            res;

    logic            out_valid_reg, out_valid_next;
    logic            spare_valid_reg, spare_valid_next;
    res_t            out_res_reg;
    res_t            spare_res_reg;
    logic            out_take;
    logic            in_accept;

    bdws_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bdws_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .key      (key),
        .room     (!spare_valid_reg),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr    (raddr),
        .rdata    (rdata),
        .done     (res_done),
        .res      (res)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // Two-entry result queue: output register plus one spare
    always_comb
    begin
        out_valid_next   = spare_valid_reg || res_done || (out_valid_reg && !out_take);
        spare_valid_next = spare_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            spare_valid_next = spare_valid_reg && res_done;
        end
        else if (res_done)
        begin
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Advance result payloads
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            out_res_reg <= spare_valid_reg ? spare_res_reg : res;
            if (spare_valid_reg && res_done)
            begin
                spare_res_reg <= res;
            end
        end
        else if (res_done)
        begin
            spare_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign position  = out_res_reg.position;

    `BDWS_ASSERT_SAME(a_no_overflow, res_done && spare_valid_reg, out_take, "result queue overflow")
    `BDWS_ASSERT_NEXT(a_scan_stalls, in_accept && mode == MODE_SEARCH && !res_done, in_stall, "input open during scan")
    `BDWS_ASSERT_SAME(a_pos_zero, out_valid && status != ST_OK, position == '0, "position set on non-hit")

endmodule

// ===== design/bdws_store.sv =====
`timescale 1ns / 1ps

module bdws_store #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [bdws_pkg::KEY_W-1:0]       wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [bdws_pkg::KEY_W-1:0]       rdata
);
    import bdws_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    // Write one key per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bdws_ctrl.sv =====
`timescale 1ns / 1ps

module bdws_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bdws_pkg::MODE_W-1:0]      mode,
    input  logic [bdws_pkg::KEY_W-1:0]       key,
    input  logic                             room,
    output logic                             we,
    output logic [$clog2(DEPTH)-1:0]         waddr,
    output logic [bdws_pkg::KEY_W-1:0]       wdata,
    output logic [$clog2(DEPTH)-1:0]         raddr,
    input  logic [bdws_pkg::KEY_W-1:0]       rdata,
    output logic                             done,
    output bdws_pkg::res_t                   res
);
    import bdws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ctrl_state_t     state_reg, state_next;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   off_reg, off_next;
    logic [KEY_W-1:0] key_reg, key_next;

    logic            in_accept;
    logic            is_full;
    logic            is_empty;
    logic [AW-1:0]   woff;
    logic [AW-1:0]   wslot;
    logic [AW-1:0]   rd_off;

    // Add an offset to a slot, wrapping at the store depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign in_stall  = !((state_reg == S_IDLE) && room);
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // Pick the write slot: one before front, after the back, or one past front
    assign woff  = (mode == MODE_INS_BACK)  ? count_reg[AW-1:0] :
                   (mode == MODE_INS_FRONT) ? AW'(DEPTH - 1) : AW'(1);
    assign wslot = slot_add(front_reg, woff);
    assign waddr = wslot;
    assign wdata = key;

    // Read the front on a new search, then the next entry each scan cycle
    assign rd_off = (state_reg == S_SCAN) ? off_reg + AW'(1) : '0;
    assign raddr  = slot_add(front_reg, rd_off);

    // Sequence one request
    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        key_next     = key_reg;
        we           = 1'b0;
        done         = 1'b0;
        res.status   = ST_OK;
        res.position = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    done = 1'b1;
                    unique case (mode_t'(mode))
                        MODE_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                front_next = wslot;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_REM_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = wslot;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_REM_BACK:
                        begin
                            if (is_empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                done       = 1'b0;
                                key_next   = key;
                                off_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Compare the entry read last cycle
                if (rdata == key_reg)
                begin
                    done         = 1'b1;
                    res.status   = ST_OK;
                    res.position = POS_W'(off_reg);
                    state_next   = S_IDLE;
                end
                else if (CW'(off_reg) + CW'(1) == count_reg)
                begin
                    done       = 1'b1;
                    res.status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    off_next = off_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Hold scan offset and search key
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        key_reg <= key_next;
    end

endmodule

// ===== dv/bounded_deque_with_search_check.sv =====
`timescale 1ns / 1ps

module bounded_deque_with_search_check #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [bdws_pkg::MODE_W-1:0]       mode,
    input  logic signed [bdws_pkg::KEY_W-1:0] key,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [bdws_pkg::STATUS_W-1:0]     status,
    input  logic [bdws_pkg::POS_W-1:0]        position,
    output int                                errors,
    output int                                pending,
    output int                                checked,
    output int                                full_count,
    output int                                empty_count,
    output int                                hit_count
);
    import bdws_pkg::*;

    localparam int PRINT_CAP = 40;

    // Shadow copy of the deque
    logic [KEY_W-1:0] key_ring [DEPTH];
    int               head_slot;
    int               live_count;

    // Answers owed by the block, oldest first
    res_t             owed_answers [$];
    res_t             oldest;

    initial
    begin
        errors      = 0;
        pending     = 0;
        checked     = 0;
        full_count  = 0;
        empty_count = 0;
        hit_count   = 0;
        head_slot   = 0;
        live_count  = 0;
    end

    // Print one line while under the print cap, and count the failure
    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP)
        begin
            $display("MISMATCH %0t ns: %s got %0d want %0d", $time, what, got, want);
        end
        errors++;
    endtask

    // Apply one request to the shadow deque and return its answer
    function automatic res_t apply_request(input logic [MODE_W-1:0] op,
                                           input logic [KEY_W-1:0] k);
        res_t ans;
        int   i;
        int   slot;
        logic hit;
        ans.status   = ST_OK;
        ans.position = '0;
        hit          = 1'b0;
        case (op)
            MODE_INS_FRONT:
            begin
                if (live_count >= DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    key_ring[head_slot] = k;
                    live_count++;
                end
            end
            MODE_INS_BACK:
            begin
                if (live_count >= DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    key_ring[(head_slot + live_count) % DEPTH] = k;
                    live_count++;
                end
            end
            MODE_REM_FRONT:
            begin
                if (live_count == 0)
                begin
                    ans.status = ST_EMPTY;
                end
                else
                begin
                    head_slot = (head_slot + 1) % DEPTH;
                    live_count--;
                end
            end
            MODE_REM_BACK:
            begin
                if (live_count == 0)
                begin
                    ans.status = ST_EMPTY;
                end
                else
                begin
                    live_count--;
                end
            end
            MODE_SEARCH:
            begin
                ans.status = ST_NOTFOUND;
                // Walk from the front and keep the first equal key
                for (i = 0; i < live_count; i++)
                begin
                    slot = (head_slot + i) % DEPTH;
                    if (!hit && key_ring[slot] == k)
                    begin
                        hit          = 1'b1;
                        ans.status   = ST_OK;
                        ans.position = i[POS_W-1:0];
                    end
                end
            end
            default:
            begin
                // Unused codes change nothing
            end
        endcase
        if (ans.status == ST_FULL)
            full_count++;
        if (ans.status == ST_EMPTY)
            empty_count++;
        if (op == MODE_SEARCH && ans.status == ST_OK)
            hit_count++;
        return ans;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot  = 0;
            live_count = 0;
            owed_answers.delete();
            pending    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                owed_answers.push_back(apply_request(mode, key));
            end
            if (out_valid && !out_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    report_mismatch("result with no request waiting, status", status, 0);
                end
                else
                begin
                    oldest = owed_answers.pop_front();
                    checked++;
                    if (status !== oldest.status)
                        report_mismatch("status", status, oldest.status);
                    if (position !== oldest.position)
                        report_mismatch("position", position, oldest.position);
                end
            end
            pending = owed_answers.size();
        end
    end

endmodule

// ===== dv/bounded_deque_with_search_test.sv =====
`timescale 1ns / 1ps

module bounded_deque_with_search_test;

    import bdws_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1730;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HISTORY_MAX  = 32;

    // Mode codes the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_MIXED
    } lean_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [MODE_W-1:0]       mode      = '0;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;

    int errors;
    int pending;
    int checked;
    int full_count;
    int empty_count;
    int hit_count;

    int cycle_count = 0;
    int insert_sent = 0;
    int remove_sent = 0;
    int search_sent = 0;
    int spare_sent  = 0;

    logic [KEY_W-1:0] key_pool [6];
    logic [KEY_W-1:0] inserted_keys [$];

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .key      (key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .position (position)
    );

    bounded_deque_with_search_check #(
        .DEPTH(DEPTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .position   (position),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .full_count (full_count),
        .empty_count(empty_count),
        .hit_count  (hit_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results owed", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the result side in regimes: none, light, half, heavy
    initial
    begin : stall_pattern
        int regime;
        int regime_left;
        regime      = 0;
        regime_left = 0;
        forever
        begin
            @(posedge clk);
            if (regime_left == 0)
            begin
                regime      = $urandom_range(0, 3);
                regime_left = $urandom_range(20, 200);
            end
            regime_left--;
            case (regime)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k);
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        case (m)
            MODE_INS_FRONT, MODE_INS_BACK: insert_sent++;
            MODE_REM_FRONT, MODE_REM_BACK: remove_sent++;
            MODE_SEARCH:                   search_sent++;
            default:                       spare_sent++;
        endcase
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Draw a key: half the time from a small pool so searches hit, else a random or an extreme key
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = $urandom;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = KEY_ZERO;
                    default: k = KEY_ONES;
                endcase
            end
            default:    k = key_pool[$urandom_range(0, 5)];
        endcase
        return k;
    endfunction

    // Draw a mode leaning toward filling, draining or searching
    function automatic logic [MODE_W-1:0] pick_mode(input lean_t lean);
        logic [MODE_W-1:0] m;
        logic [MODE_W-1:0] ins;
        logic [MODE_W-1:0] rem;
        int                roll;
        int                kind;
        roll = $urandom_range(0, 99);
        kind = $urandom_range(0, 99);
        ins  = $urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT;
        rem  = $urandom_range(0, 1) ? MODE_REM_BACK : MODE_REM_FRONT;
        if (roll == 0)
            m = MODE_SPARE_5;
        else if (roll == 1)
            m = MODE_SPARE_6;
        else if (roll == 2)
            m = MODE_SPARE_7;
        else
        begin
            case (lean)
                LEAN_FILL:  m = (kind < 70) ? ins : (kind < 85) ? MODE_SEARCH : rem;
                LEAN_DRAIN: m = (kind < 70) ? rem : (kind < 85) ? MODE_SEARCH : ins;
                default:    m = (kind < 50) ? MODE_SEARCH : (kind < 75) ? ins : rem;
            endcase
        end
        return m;
    endfunction

    // Make one random request, searching mostly for keys that went in lately
    task automatic send_random(input lean_t lean);
        logic [MODE_W-1:0] m;
        logic [KEY_W-1:0]  k;
        m = pick_mode(lean);
        k = pick_key();
        if (m == MODE_SEARCH && inserted_keys.size() != 0 && $urandom_range(0, 9) < 6)
            k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (m == MODE_INS_FRONT || m == MODE_INS_BACK)
        begin
            inserted_keys.push_back(k);
            if (inserted_keys.size() > HISTORY_MAX)
                void'(inserted_keys.pop_front());
        end
        send_request(m, k);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int    sent;
        int    burst_len;
        int    gap;
        int    j;
        int    lean_left;
        lean_t lean;
        logic  paused;

        sent      = 0;
        lean_left = 0;
        lean      = LEAN_FILL;
        paused    = 1'b0;
        for (j = 0; j < 6; j++)
            key_pool[j] = $urandom;
        key_pool[0] = KEY_MIN;

        // Hold reset, then release
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Removes and search on an empty store, unused codes
        send_request(MODE_REM_FRONT, KEY_ONES);
        send_request(MODE_REM_BACK, KEY_ZERO);
        send_request(MODE_SEARCH, KEY_ZERO);
        send_request(MODE_SPARE_5, KEY_ONES);
        send_request(MODE_SPARE_6, KEY_MIN);
        send_request(MODE_SPARE_7, KEY_MAX);
        // Extreme keys at both ends, front insert wraps the ring
        send_request(MODE_INS_BACK, KEY_MAX);
        send_request(MODE_INS_FRONT, KEY_MIN);
        send_request(MODE_SEARCH, KEY_MIN);
        send_request(MODE_SEARCH, KEY_MAX);
        send_request(MODE_SEARCH, KEY_ZERO);
        // Duplicate key: first match from the front wins
        send_request(MODE_INS_BACK, KEY_MIN);
        send_request(MODE_SEARCH, KEY_MIN);
        send_request(MODE_REM_FRONT, KEY_ZERO);
        send_request(MODE_SEARCH, KEY_MIN);
        send_request(MODE_INS_FRONT, KEY_ONES);
        send_request(MODE_SEARCH, KEY_ONES);
        // Drain past empty
        send_request(MODE_REM_BACK, KEY_ZERO);
        send_request(MODE_REM_BACK, KEY_ZERO);
        send_request(MODE_REM_FRONT, KEY_ZERO);
        send_request(MODE_REM_BACK, KEY_ZERO);
        hold_until_drained();

        // Random bursts with random gaps, leaning in stretches
        while (sent < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 24);
            for (j = 0; j < burst_len && sent < RANDOM_ITEMS; j++)
            begin
                if (lean_left == 0)
                begin
                    lean      = lean_t'($urandom_range(0, 2));
                    lean_left = $urandom_range(10, 60);
                end
                lean_left--;
                send_random(lean);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Pause once midway until the block has answered everything
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        // Wait out the last results and idle longer than a full search
        hold_until_drained();
        repeat (DEPTH + 4) @(posedge clk);

        $display("Sent %0d inserts, %0d removes, %0d searches, %0d unused codes; %0d compared",
                 insert_sent, remove_sent, search_sent, spare_sent, checked);
        $display("Inserts refused on full: %0d, removes on empty: %0d, search hits: %0d",
                 full_count, empty_count, hit_count);
        if (errors == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bdws_pkg.sv
design/bdws_store.sv
design/bdws_ctrl.sv
design/bounded_deque_with_search.sv
dv/bounded_deque_with_search_check.sv
dv/bounded_deque_with_search_test.sv
